// File: rtl/fpfa_pkg.sv
`default_nettype none

package fpfa_pkg;

   localparam int unsigned SIZE_W   = 16;
   localparam int unsigned ID_W     = 16;
   localparam int unsigned ENTRY_W  = 3;
   localparam int unsigned COUNT_W  = 4;
   localparam int unsigned POLICY_W = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

   localparam logic ACTION_DEFINE  = 1'b0;
   localparam logic ACTION_REQUEST = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage

`default_nettype wire

// File: rtl/fixed_partition_fit_allocator.sv
// channel   ports                                   handshake
// request   req_action, req_entry_index,            taken when start & !busy
//           req_block_size, req_requester_id
// result    rsp_granted, rsp_chosen_index,          one cycle under rsp_valid
//           rsp_leftover, rsp_grant_total
// config    csr_write_enable, csr_write_data        written when csr_write_enable
//
// a define beat is done while idle: its result shows in the next cycle, busy stays low
// a request beat steps through SCAN, DRAIN and FINISH: one slot per cycle through the shared
// subtract/compare unit, a registered slot memory read, then a commit
// busy is high in SCAN, DRAIN and FINISH after a request is taken
// reset (synchronous) clears the policy, valid and busy marks and the grant count
// the receiver cannot stall: each result is shown for exactly one cycle
`default_nettype none

module fixed_partition_fit_allocator
   import fpfa_pkg::*;
#(
   parameter int unsigned NUM_SLOTS = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output      logic                busy,
   input  wire logic                req_action,
   input  wire logic [ENTRY_W-1:0]  req_entry_index,
   input  wire logic [SIZE_W-1:0]   req_block_size,
   input  wire logic [ID_W-1:0]     req_requester_id,
   output      logic                rsp_valid,
   output      logic                rsp_granted,
   output      logic [ENTRY_W-1:0]  rsp_chosen_index,
   output      logic [SIZE_W-1:0]   rsp_leftover,
   output      logic [COUNT_W-1:0]  rsp_grant_total,
   input  wire logic                csr_write_enable,
   input  wire logic [POLICY_W-1:0] csr_write_data
);

   localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

   state_type state_ff, state_in;

   logic [POLICY_W-1:0] policy_ff;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [NUM_SLOTS-1:0] taken_ff, taken_in;
   logic [COUNT_W-1:0] grants_ff, grants_in;

   logic [SIZE_W-1:0] slot_size_ff [NUM_SLOTS];
   logic [ID_W-1:0]   slot_owner_ff [NUM_SLOTS];

   logic [SIZE_W-1:0] want_ff, want_in;
   logic [ID_W-1:0]   owner_ff, owner_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;

   logic [SIZE_W-1:0] rd_size_ff;
   logic [SLOT_W-1:0] rd_slot_ff;
   logic              rd_go_ff, rd_go_in;

   logic              found_ff, found_in;
   logic [SLOT_W-1:0] pick_ff, pick_in;
   logic [SIZE_W-1:0] waste_ff, waste_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_granted_ff, rsp_granted_in;
   logic [ENTRY_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [SIZE_W-1:0]   rsp_leftover_ff, rsp_leftover_in;

   logic              accept;
   logic              define_ok;
   logic [SLOT_W-1:0] def_slot;
   logic              slot_ok;
   logic              fits;
   logic [SIZE_W-1:0] waste;
   logic              take;
   logic              commit;

   assign accept    = start && (state_ff == ST_IDLE);
   assign def_slot  = SLOT_W'(req_entry_index);
   assign define_ok = accept && (req_action == ACTION_DEFINE)
                      && (32'(req_entry_index) < NUM_SLOTS);
   assign commit    = (state_ff == ST_FINISH) && found_ff;

   // shared compare and subtract unit, one slot per cycle
   assign slot_ok = valid_ff[rd_slot_ff] && !taken_ff[rd_slot_ff];
   assign fits    = rd_go_ff && slot_ok && (rd_size_ff >= want_ff);
   assign waste   = rd_size_ff - want_ff;

   always_comb begin
      take = 1'b0;
      if (fits) begin
         if (!found_ff) begin
            take = 1'b1;
         end else begin
            case (policy_ff)
               POLICY_BEST:  take = (waste < waste_ff);
               POLICY_WORST: take = (waste > waste_ff);
               default:      take = 1'b0;
            endcase
         end
      end
   end

   always_comb begin
      state_in        = state_ff;
      valid_in        = valid_ff;
      taken_in        = taken_ff;
      grants_in       = grants_ff;
      want_in         = want_ff;
      owner_in        = owner_ff;
      cnt_in          = cnt_ff;
      rd_go_in        = 1'b0;
      found_in        = found_ff;
      pick_in         = pick_ff;
      waste_in        = waste_ff;
      rsp_valid_in    = 1'b0;
      rsp_granted_in  = rsp_granted_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_leftover_in = rsp_leftover_ff;

      if (take) begin
         found_in = 1'b1;
         pick_in  = rd_slot_ff;
         waste_in = waste;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACTION_REQUEST) begin
                  want_in  = req_block_size;
                  owner_in = req_requester_id;
                  cnt_in   = '0;
                  found_in = 1'b0;
                  pick_in  = '0;
                  waste_in = '0;
                  state_in = ST_SCAN;
               end else begin
                  if (define_ok) begin
                     valid_in[def_slot] = 1'b1;
                     taken_in[def_slot] = 1'b0;
                     grants_in          = '0;
                  end
                  rsp_valid_in    = 1'b1;
                  rsp_granted_in  = 1'b0;
                  rsp_index_in    = '0;
                  rsp_leftover_in = '0;
               end
            end
         end
         ST_SCAN: begin
            rd_go_in = 1'b1;
            if (cnt_ff == LAST_SLOT) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            if (found_ff) begin
               taken_in[pick_ff] = 1'b1;
               if (grants_ff != COUNT_MAX) begin
                  grants_in = grants_ff + 1'b1;
               end
               rsp_granted_in  = 1'b1;
               rsp_index_in    = ENTRY_W'(pick_ff);
               rsp_leftover_in = waste_ff;
            end else begin
               rsp_granted_in  = 1'b0;
               rsp_index_in    = '0;
               rsp_leftover_in = '0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= POLICY_FIRST;
         valid_ff     <= '0;
         taken_ff     <= '0;
         grants_ff    <= '0;
         rd_go_ff     <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         taken_ff     <= taken_in;
         grants_ff    <= grants_in;
         rd_go_ff     <= rd_go_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            policy_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      want_ff         <= want_in;
      owner_ff        <= owner_in;
      cnt_ff          <= cnt_in;
      pick_ff         <= pick_in;
      waste_ff        <= waste_in;
      rsp_granted_ff  <= rsp_granted_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_leftover_ff <= rsp_leftover_in;
   end

   // partition size memory
   always_ff @(posedge clock) begin
      if (define_ok) begin
         slot_size_ff[def_slot] <= req_block_size;
      end
      rd_size_ff <= slot_size_ff[cnt_ff];
      rd_slot_ff <= cnt_ff;
   end

   // owner memory
   always_ff @(posedge clock) begin
      if (commit) begin
         slot_owner_ff[pick_ff] <= owner_ff;
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_chosen_index = rsp_index_ff;
   assign rsp_leftover     = rsp_leftover_ff;
   assign rsp_grant_total  = grants_ff;

endmodule

`default_nettype wire

// File: verif/fixed_partition_fit_allocator_tb.sv
module fixed_partition_fit_allocator_tb
   import fpfa_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOT_COUNT = 8;
   localparam int SETTLE_CYCLES = SLOT_COUNT + 6;
   localparam logic [POLICY_W-1:0] POLICY_UNUSED = 2'd3;

   typedef struct packed {
      logic               granted;
      logic [ENTRY_W-1:0] index;
      logic [SIZE_W-1:0]  leftover;
      logic [COUNT_W-1:0] total;
   } grant_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_action = ACTION_DEFINE;
   logic [ENTRY_W-1:0]  req_entry_index = '0;
   logic [SIZE_W-1:0]   req_block_size = '0;
   logic [ID_W-1:0]     req_requester_id = '0;
   logic                rsp_valid;
   logic                rsp_granted;
   logic [ENTRY_W-1:0]  rsp_chosen_index;
   logic [SIZE_W-1:0]   rsp_leftover;
   logic [COUNT_W-1:0]  rsp_grant_total;
   logic                csr_write_enable = 1'b0;
   logic [POLICY_W-1:0] csr_write_data = '0;

   // partition table as the allocator should hold it
   logic [SIZE_W-1:0]   part_size [SLOT_COUNT];
   logic                part_live [SLOT_COUNT];
   logic                part_taken [SLOT_COUNT];
   logic [COUNT_W-1:0]  grant_count = '0;
   logic [POLICY_W-1:0] fit_mode = POLICY_FIRST;

   grant_t expected_grants[$];
   int     mismatches = 0;
   int     beats_sent = 0;
   bit     pacing = 1'b0;

   fixed_partition_fit_allocator #(
      .NUM_SLOTS(SLOT_COUNT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_entry_index(req_entry_index),
      .req_block_size(req_block_size),
      .req_requester_id(req_requester_id),
      .rsp_valid(rsp_valid),
      .rsp_granted(rsp_granted),
      .rsp_chosen_index(rsp_chosen_index),
      .rsp_leftover(rsp_leftover),
      .rsp_grant_total(rsp_grant_total),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic grant_t predict_allocation(input logic action,
                                                 input logic [ENTRY_W-1:0] entry,
                                                 input logic [SIZE_W-1:0] size);
      grant_t            res;
      logic              found;
      int                pick;
      logic [SIZE_W-1:0] pick_waste;
      logic [SIZE_W-1:0] waste;
      res = '0;
      found = 1'b0;
      pick = 0;
      pick_waste = '0;
      if (action == ACTION_DEFINE) begin
         if (entry < SLOT_COUNT) begin
            part_size[entry] = size;
            part_live[entry] = 1'b1;
            part_taken[entry] = 1'b0;
            grant_count = '0;
         end
      end else begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (part_live[i] && !part_taken[i] && part_size[i] >= size) begin
               waste = part_size[i] - size;
               if (!found) begin
                  found = 1'b1;
                  pick = i;
                  pick_waste = waste;
                  if (fit_mode != POLICY_BEST && fit_mode != POLICY_WORST) break;
               end else if (fit_mode == POLICY_BEST && waste < pick_waste) begin
                  pick = i;
                  pick_waste = waste;
               end else if (fit_mode == POLICY_WORST && waste > pick_waste) begin
                  pick = i;
                  pick_waste = waste;
               end
            end
         end
         if (found) begin
            part_taken[pick] = 1'b1;
            if (grant_count != COUNT_MAX) grant_count = grant_count + 1'b1;
            res.granted = 1'b1;
            res.index = pick[ENTRY_W-1:0];
            res.leftover = pick_waste;
         end
      end
      res.total = grant_count;
      return res;
   endfunction

   function automatic logic [SIZE_W-1:0] draw_size();
      case ($urandom_range(0, 4))
         0: return SIZE_W'($urandom_range(0, 65535));
         1: return SIZE_W'($urandom_range(0, 255));
         2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         3: return SIZE_W'($urandom_range(0, 4095));
         default: return SIZE_W'($urandom_range(1, 4) * 64);
      endcase
   endfunction

   // mostly sizes that fit a free partition exactly, nearly, or just miss it
   function automatic logic [SIZE_W-1:0] draw_request_size();
      int                free_slots[$];
      logic [SIZE_W-1:0] s;
      for (int i = 0; i < SLOT_COUNT; i++)
         if (part_live[i] && !part_taken[i]) free_slots.push_back(i);
      if (free_slots.size() == 0 || $urandom_range(0, 4) == 0) return draw_size();
      s = part_size[free_slots[$urandom_range(0, free_slots.size() - 1)]];
      case ($urandom_range(0, 3))
         0: return s;
         1: return (s == 16'hFFFF) ? s : s + 1'b1;
         default: return s - SIZE_W'($urandom_range(0, (s < 300) ? s : 300));
      endcase
   endfunction

   task automatic send_beat(input logic action, input logic [ENTRY_W-1:0] entry,
                            input logic [SIZE_W-1:0] size, input logic [ID_W-1:0] id);
      if (pacing && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      start <= 1'b1;
      req_action <= action;
      req_entry_index <= entry;
      req_block_size <= size;
      req_requester_id <= id;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_grants.push_back(predict_allocation(action, entry, size));
      beats_sent++;
   endtask

   task automatic settle();
      start <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_policy(input logic [POLICY_W-1:0] mode);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      fit_mode = mode;
   endtask

   always @(posedge clock) begin : check_results
      grant_t want;
      grant_t got;
      if (!reset && rsp_valid === 1'b1) begin
         got = {rsp_granted, rsp_chosen_index, rsp_leftover, rsp_grant_total};
         if (expected_grants.size() == 0) begin
            $display("%0t: unexpected result beat granted=%0b index=%0d leftover=%0d total=%0d",
                     $time, got.granted, got.index, got.leftover, got.total);
            mismatches++;
         end else begin
            want = expected_grants.pop_front();
            if (got !== want) begin
               $display("%0t: expected granted=%0b index=%0d leftover=%0d total=%0d",
                        $time, want.granted, want.index, want.leftover, want.total);
               $display("%0t: actual   granted=%0b index=%0d leftover=%0d total=%0d",
                        $time, got.granted, got.index, got.leftover, got.total);
               mismatches++;
            end
         end
      end
   end

   task automatic test_empty_and_extremes();
      send_beat(ACTION_REQUEST, 3'd5, 16'd0, 16'd0);
      send_beat(ACTION_DEFINE, 3'd7, 16'hFFFF, 16'hFFFF);
      send_beat(ACTION_DEFINE, 3'd0, 16'd0, 16'd0);
      send_beat(ACTION_REQUEST, 3'd0, 16'd0, 16'hFFFF);
      send_beat(ACTION_REQUEST, 3'd7, 16'hFFFF, 16'h1234);
      send_beat(ACTION_REQUEST, 3'd2, 16'd1, 16'h4321);
      // redefine a taken partition
      send_beat(ACTION_DEFINE, 3'd7, 16'hFFFF, 16'd0);
      send_beat(ACTION_REQUEST, 3'd1, 16'd0, 16'hA5A5);
      send_beat(ACTION_REQUEST, 3'd4, 16'd0, 16'h5A5A);
   endtask

   task automatic test_fit_policies();
      logic [SIZE_W-1:0] sizes [SLOT_COUNT] = '{16'd120, 16'd100, 16'd500, 16'd100,
                                               16'd500, 16'd40, 16'd200, 16'hFFFF};
      for (int i = 0; i < SLOT_COUNT; i++)
         send_beat(ACTION_DEFINE, i[ENTRY_W-1:0], sizes[i], 16'd0);
      set_policy(POLICY_BEST);
      send_beat(ACTION_REQUEST, 3'd0, 16'd100, 16'd1);
      send_beat(ACTION_REQUEST, 3'd0, 16'd100, 16'd2);
      set_policy(POLICY_WORST);
      send_beat(ACTION_REQUEST, 3'd0, 16'd50, 16'd3);
      send_beat(ACTION_REQUEST, 3'd0, 16'd50, 16'd4);
      set_policy(POLICY_UNUSED);
      send_beat(ACTION_REQUEST, 3'd0, 16'd30, 16'd5);
      set_policy(POLICY_FIRST);
      send_beat(ACTION_REQUEST, 3'd0, 16'd30, 16'd6);
      send_beat(ACTION_REQUEST, 3'd0, 16'hFFFF, 16'd7);
   endtask

   // table definitions followed by requests, with some stray beats mixed in; allow_gaps adds policy changes and pauses
   task automatic test_random_traffic(input int beats, input bit allow_gaps);
      int stop_at;
      stop_at = beats_sent + beats;
      while (beats_sent < stop_at) begin
         if (allow_gaps && $urandom_range(0, 3) == 0)
            set_policy(POLICY_W'($urandom_range(0, 3)));
         else if (allow_gaps && $urandom_range(0, 5) == 0) settle();
         pacing = allow_gaps && ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(1, SLOT_COUNT))
            send_beat(ACTION_DEFINE, ENTRY_W'($urandom_range(0, 7)), draw_size(),
                      ID_W'($urandom_range(0, 65535)));
         repeat ($urandom_range(1, 10))
            send_beat(ACTION_REQUEST, ENTRY_W'($urandom_range(0, 7)), draw_request_size(),
                      ID_W'($urandom_range(0, 65535)));
         repeat ($urandom_range(0, 2))
            send_beat(1'($urandom_range(0, 1)), ENTRY_W'($urandom_range(0, 7)),
                      SIZE_W'($urandom_range(0, 65535)), ID_W'($urandom_range(0, 65535)));
      end
      pacing = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         part_size[i] = '0;
         part_live[i] = 1'b0;
         part_taken[i] = 1'b0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_extremes();
      test_fit_policies();
      test_random_traffic(1400, 1'b1);
      test_random_traffic(300, 1'b0);
      start <= 1'b0;
      for (int w = 0; w < 200 && expected_grants.size() != 0; w++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_grants.size() != 0) begin
         $display("%0t: %0d result beats never arrived", $time, expected_grants.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/fpfa_pkg.sv
rtl/fixed_partition_fit_allocator.sv
verif/fixed_partition_fit_allocator_tb.sv
